### hdl/gpfe_pkg.sv
// Shared types, constants and exp tables for the Gaussian peak field evaluator.
package gpfe_pkg;

  localparam int unsigned PEAKS_DEF = 16;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned FIELD_W = 24;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 24'hFFFFFF;
  localparam logic [12:0] EXP_CUTOFF = 13'd4096;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_RIGHT  = 2'd1,
    REG_BOTTOM = 2'd2,
    REG_TOP    = 2'd3
  } reg_idx_t;

  typedef enum logic {
    ACT_APPEND = 1'b0,
    ACT_EVAL   = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_RDW,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SQS,
    ST_DIV,
    ST_EXP1,
    ST_EXP2,
    ST_EXP3,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

  // Divider control/status between sequencer and divide unit.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic [16:0] exp_int(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0: r = 17'd65536; 4'd1: r = 17'd24109; 4'd2: r = 17'd8869;
      4'd3: r = 17'd3263;  4'd4: r = 17'd1200;  4'd5: r = 17'd442;
      4'd6: r = 17'd162;   4'd7: r = 17'd60;    4'd8: r = 17'd22;
      4'd9: r = 17'd8;     4'd10: r = 17'd3;    4'd11: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] exp_six(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0: r = 17'd65536;  4'd1: r = 17'd61565;  4'd2: r = 17'd57835;
      4'd3: r = 17'd54331;  4'd4: r = 17'd51039;  4'd5: r = 17'd47947;
      4'd6: r = 17'd45042;  4'd7: r = 17'd42313;  4'd8: r = 17'd39750;
      4'd9: r = 17'd37341;  4'd10: r = 17'd35079; 4'd11: r = 17'd32954;
      4'd12: r = 17'd30957; 4'd13: r = 17'd29081; 4'd14: r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] exp_fine(input logic [3:0] i);
    logic [16:0] r;
    case (i)
      4'd0: r = 17'd65536;  4'd1: r = 17'd65280;  4'd2: r = 17'd65027;
      4'd3: r = 17'd64772;  4'd4: r = 17'd64520;  4'd5: r = 17'd64268;
      4'd6: r = 17'd64018;  4'd7: r = 17'd63768;  4'd8: r = 17'd63520;
      4'd9: r = 17'd63272;  4'd10: r = 17'd63025; 4'd11: r = 17'd62780;
      4'd12: r = 17'd62535; 4'd13: r = 17'd62291; 4'd14: r = 17'd62048;
      default: r = 17'd61806;
    endcase
    return r;
  endfunction

endpackage

### hdl/gaussian_peak_field_evaluator_top.sv
// Top level of the Gaussian peak field evaluator: sequencer, peak table, datapath.
//
// Usage:
//  - Input channel (in_valid/in_ready): one request per item. in_action selects
//    append-peak or evaluate-point; point, height and spread ride alongside.
//  - Output channel (out_valid/out_ready): one result per request: field_value,
//    in_region, status.
//  - Config port: cfg_we writes cfg_data[15:0] to register cfg_index (0 left,
//    1 right, 2 bottom, 3 top edge). Unknown indexes are ignored.
//  - Results: an append, or an evaluation of an empty table, raises out_valid at
//    the accepting edge. An evaluation walks the stored peaks one at a time
//    through a shared multiplier and a restoring divider, then raises out_valid.
//  - Throughput: one request at a time; in_ready is low from accept until the
//    result has been taken.
//  - Reset (rst_n low, synchronous): empties the peak table, restores the full
//    region, drops any pending result. Table contents are not cleared.
//  - Stall: a held result stays on out_* until out_ready; no new request enters.
module gaussian_peak_field_evaluator_top #(
  parameter int unsigned PEAKS = gpfe_pkg::PEAKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [15:0] in_point_x,
  input  logic [15:0] in_point_y,
  input  logic [15:0] in_peak_height,
  input  logic [15:0] in_peak_spread,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] out_field_value,
  output logic        out_in_region,
  output logic        out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned AW = (PEAKS > 1) ? $clog2(PEAKS) : 1;
  localparam int unsigned CW = $clog2(PEAKS + 1);

  gpfe_pkg::state_t state_r, state_nxt;

  logic signed [15:0] left_r, right_r, bottom_r, top_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      k_r;
  logic signed [15:0] qx_r, qy_r;
  logic [23:0]        sum_r;
  logic               region_r, status_r;
  logic               out_valid_r;
  logic signed [16:0] dx_r, dy_r;
  logic [33:0]        num_r;
  logic [32:0]        den_r;
  logic [41:0]        u_r;
  logic [16:0]        t_r;
  logic [16:0]        e_r;
  logic [15:0]        cont_r;

  logic               accept;
  logic               ram_we;
  logic [63:0]        ram_wdata, ram_rdata;
  logic [AW-1:0]      ram_waddr, ram_raddr;

  gpfe_pkg::div_ctl_t div_ctl;
  gpfe_pkg::div_sts_t div_sts;
  logic [41:0]        quot;

  // shared multiplier: 17x17 unsigned
  logic [16:0] mul_a, mul_b;
  logic [33:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [15:0] cx, cy;
  logic [15:0]        ch, cs;
  assign cx = ram_rdata[63:48];
  assign cy = ram_rdata[47:32];
  assign ch = ram_rdata[31:16];
  assign cs = (ram_rdata[15:0] == 16'd0) ? 16'd1 : ram_rdata[15:0];

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == gpfe_pkg::ST_IDLE);
  assign ram_we    = accept && (in_action == gpfe_pkg::ACT_APPEND) &&
                     (count_r < CW'(PEAKS));
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = {in_point_x, in_point_y, in_peak_height, in_peak_spread};
  assign ram_raddr = k_r[AW-1:0];

  gpfe_ram #(.WIDTH(64), .DEPTH(PEAKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gpfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend ({num_r, 8'd0}),
    .divisor  (den_r),
    .sts      (div_sts),
    .quotient (quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gpfe_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_action == gpfe_pkg::ACT_EVAL && count_r != '0) begin
            state_nxt = gpfe_pkg::ST_RD;
          end else begin
            state_nxt = gpfe_pkg::ST_OUT;
          end
        end
      end
      gpfe_pkg::ST_RD:   state_nxt = gpfe_pkg::ST_RDW;
      gpfe_pkg::ST_RDW:  state_nxt = gpfe_pkg::ST_DIFF;
      gpfe_pkg::ST_DIFF: state_nxt = gpfe_pkg::ST_SQX;
      gpfe_pkg::ST_SQX:  state_nxt = gpfe_pkg::ST_SQY;
      gpfe_pkg::ST_SQY:  state_nxt = gpfe_pkg::ST_SQS;
      gpfe_pkg::ST_SQS:  state_nxt = gpfe_pkg::ST_DIV;
      gpfe_pkg::ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = gpfe_pkg::ST_EXP1;
        end
      end
      gpfe_pkg::ST_EXP1: state_nxt = gpfe_pkg::ST_EXP2;
      gpfe_pkg::ST_EXP2: state_nxt = gpfe_pkg::ST_EXP3;
      gpfe_pkg::ST_EXP3: state_nxt = gpfe_pkg::ST_MUL;
      gpfe_pkg::ST_MUL:  state_nxt = gpfe_pkg::ST_ACC;
      gpfe_pkg::ST_ACC: begin
        if (k_r + CW'(1) >= count_r) begin
          state_nxt = gpfe_pkg::ST_OUT;
        end else begin
          state_nxt = gpfe_pkg::ST_RD;
        end
      end
      gpfe_pkg::ST_OUT: begin
        if (out_ready) begin
          state_nxt = gpfe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gpfe_pkg::ST_IDLE;
    endcase
  end

  // outputs: multiplier operand select and divider start
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_ctl.start = 1'b0;
    unique case (state_r)
      gpfe_pkg::ST_SQX: begin
        mul_a = dx_r[16] ? 17'(-dx_r) : 17'(dx_r);
        mul_b = mul_a;
      end
      gpfe_pkg::ST_SQY: begin
        mul_a = dy_r[16] ? 17'(-dy_r) : 17'(dy_r);
        mul_b = mul_a;
      end
      gpfe_pkg::ST_SQS: begin
        mul_a = {1'b0, cs};
        mul_b = {1'b0, cs};
        div_ctl.start = 1'b0;
      end
      gpfe_pkg::ST_EXP2: begin
        mul_a = gpfe_pkg::exp_int(u_r[11:8]);
        mul_b = gpfe_pkg::exp_six(u_r[7:4]);
      end
      gpfe_pkg::ST_EXP3: begin
        mul_a = t_r;
        mul_b = gpfe_pkg::exp_fine(u_r[3:0]);
      end
      gpfe_pkg::ST_MUL: begin
        mul_a = {1'b0, ch};
        mul_b = e_r;
      end
      gpfe_pkg::ST_DIV: div_ctl.start = !div_sts.busy && !div_sts.done && !u_r[41];
      default: ;
    endcase
  end

  // u_r[41] is borrowed as a "divider launched" flag while in ST_DIV.
  logic [34:0] prod_t;
  assign prod_t = {1'b0, mul_p} + 35'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gpfe_pkg::ST_IDLE;
      count_r     <= '0;
      left_r      <= 16'sh8000;
      right_r     <= 16'sh7FFF;
      bottom_r    <= 16'sh8000;
      top_r       <= 16'sh7FFF;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (gpfe_pkg::reg_idx_t'(cfg_index))
          gpfe_pkg::REG_LEFT:   left_r   <= cfg_data;
          gpfe_pkg::REG_RIGHT:  right_r  <= cfg_data;
          gpfe_pkg::REG_BOTTOM: bottom_r <= cfg_data;
          gpfe_pkg::REG_TOP:    top_r    <= cfg_data;
          default: ;
        endcase
      end
      if (ram_we) begin
        count_r <= count_r + CW'(1);
      end
      if (accept) begin
        k_r <= '0;
      end else if (state_r == gpfe_pkg::ST_ACC) begin
        k_r <= k_r + CW'(1);
      end
      out_valid_r <= (state_nxt == gpfe_pkg::ST_OUT);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      qx_r     <= in_point_x;
      qy_r     <= in_point_y;
      sum_r    <= '0;
      status_r <= (in_action == gpfe_pkg::ACT_APPEND) && (count_r >= CW'(PEAKS));
      region_r <= (in_action == gpfe_pkg::ACT_EVAL) &&
                  ($signed(in_point_x) >= left_r) && ($signed(in_point_x) <= right_r) &&
                  ($signed(in_point_y) >= bottom_r) && ($signed(in_point_y) <= top_r);
    end
    unique case (state_r)
      gpfe_pkg::ST_DIFF: begin
        dx_r <= 17'(qx_r) - 17'(cx);
        dy_r <= 17'(qy_r) - 17'(cy);
        u_r  <= '0;
      end
      gpfe_pkg::ST_SQX: num_r <= mul_p;
      gpfe_pkg::ST_SQY: num_r <= num_r + mul_p;
      gpfe_pkg::ST_SQS: den_r <= {mul_p[31:0], 1'b0};
      gpfe_pkg::ST_DIV: begin
        if (div_ctl.start) begin
          u_r[41] <= 1'b1;
        end
      end
      gpfe_pkg::ST_EXP1: u_r <= quot;
      gpfe_pkg::ST_EXP2: t_r <= 17'(prod_t[34:16]);
      gpfe_pkg::ST_EXP3: e_r <= (u_r >= 42'(gpfe_pkg::EXP_CUTOFF)) ? 17'd0 :
                                17'(prod_t[34:16]);
      gpfe_pkg::ST_MUL:  cont_r <= mul_p[31:16];
      gpfe_pkg::ST_ACC: begin
        if ({1'b0, sum_r} + 25'(cont_r) > 25'(gpfe_pkg::FIELD_MAX)) begin
          sum_r <= gpfe_pkg::FIELD_MAX;
        end else begin
          sum_r <= sum_r + 24'(cont_r);
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_field_value = sum_r;
  assign out_in_region   = region_r;
  assign out_status      = status_r;

  property p_busy_not_ready;
    @(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready;
  endproperty
  a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while result held");

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= CW'(PEAKS);
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("peak count overflow");

  property p_append_zero;
    @(posedge clk) disable iff (!rst_n) out_valid && out_status |-> out_field_value == '0;
  endproperty
  a_append_zero: assert property (p_append_zero) else $error("refused append with value");

endmodule

### hdl/gpfe_ram.sv
// Generic RAM with one write port and one registered read port.
module gpfe_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/gpfe_div.sv
// Restoring divider, one quotient bit per cycle: 42-bit dividend / 33-bit divisor.
module gpfe_div (
  input  logic                clk,
  input  logic                rst_n,
  input  gpfe_pkg::div_ctl_t  ctl,
  input  logic [41:0]         dividend,
  input  logic [32:0]         divisor,
  output gpfe_pkg::div_sts_t  sts,
  output logic [41:0]         quotient
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [41:0] quo_r, quo_nxt;
  logic [32:0] dvs_r, dvs_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] shifted;
  logic [34:0] diff;

  assign shifted = {rem_r[32:0], quo_r[41]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      cnt_nxt  = 6'd42;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[34]) begin
        rem_nxt = diff[33:0];
        quo_nxt = {quo_r[40:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[40:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

  property p_no_restart;
    @(posedge clk) disable iff (!rst_n) busy_r |-> !ctl.start;
  endproperty
  a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) sts.done |-> $past(busy_r);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");

  property p_quot_fits;
    @(posedge clk) disable iff (!rst_n) $rose(busy_r) |-> cnt_r == 6'd42;
  endproperty
  a_quot_fits: assert property (p_quot_fits) else $error("bad divider count");

endmodule

### dv/gpfe_checker.sv
// Request/result checker for the Gaussian peak field evaluator.
`timescale 1ns / 100ps

module gpfe_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [15:0] in_point_x,
  input  logic [15:0] in_point_y,
  input  logic [15:0] in_peak_height,
  input  logic [15:0] in_peak_spread,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [23:0] out_field_value,
  input  logic        out_in_region,
  input  logic        out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          fail_count
);

  typedef struct packed {
    logic [23:0] field;
    logic        region;
    logic        status;
  } field_result_t;

  localparam int unsigned TABLE_DEPTH = gpfe_pkg::PEAKS_DEF;

  // exp(-i), exp(-h/16), exp(-l/256) in Q.16
  localparam longint unsigned EXP_WHOLE [16] = '{
    65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1, 0, 0, 0, 0};
  localparam longint unsigned EXP_SIXTEENTH [16] = '{
    65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
    39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
  localparam longint unsigned EXP_FINE [16] = '{
    65536, 65280, 65027, 64772, 64520, 64268, 64018, 63768,
    63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};

  logic signed [15:0] peak_cx [TABLE_DEPTH];
  logic signed [15:0] peak_cy [TABLE_DEPTH];
  logic [15:0]        peak_amp [TABLE_DEPTH];
  logic [15:0]        peak_sigma [TABLE_DEPTH];
  int                 stored_peaks;
  logic signed [15:0] edge_left, edge_right, edge_bottom, edge_top;
  field_result_t      expected_results [$];

  function automatic longint unsigned gauss_q16(longint unsigned u);
    longint unsigned t;
    if (u >= 4096) return 0;
    t = (EXP_WHOLE[u[11:8]] * EXP_SIXTEENTH[u[7:4]] + 32768) >> 16;
    return (t * EXP_FINE[u[3:0]] + 32768) >> 16;
  endfunction

  function automatic logic [23:0] field_at(logic signed [15:0] x, logic signed [15:0] y);
    longint          dx, dy;
    longint unsigned num, s, u, sum;
    sum = 0;
    for (int k = 0; k < stored_peaks; k++) begin
      dx = longint'(x) - longint'(peak_cx[k]);
      dy = longint'(y) - longint'(peak_cy[k]);
      num = dx * dx + dy * dy;
      s = (peak_sigma[k] == 0) ? 1 : peak_sigma[k];
      u = (num * 256) / (2 * s * s);
      sum += (longint'(peak_amp[k]) * gauss_q16(u)) >> 16;
      if (sum > 24'hFFFFFF) sum = 24'hFFFFFF;
    end
    return sum[23:0];
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    field_result_t r, e;
    logic signed [15:0] px, py;
    if (!rst_n) begin
      stored_peaks = 0;
      edge_left = -16'sd32768;
      edge_right = 16'sd32767;
      edge_bottom = -16'sd32768;
      edge_top = 16'sd32767;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (gpfe_pkg::reg_idx_t'(cfg_index))
          gpfe_pkg::REG_LEFT:   edge_left = cfg_data;
          gpfe_pkg::REG_RIGHT:  edge_right = cfg_data;
          gpfe_pkg::REG_BOTTOM: edge_bottom = cfg_data;
          gpfe_pkg::REG_TOP:    edge_top = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        r = '0;
        px = in_point_x;
        py = in_point_y;
        if (gpfe_pkg::action_t'(in_action) == gpfe_pkg::ACT_APPEND) begin
          if (stored_peaks >= TABLE_DEPTH) begin
            r.status = 1'b1;
          end else begin
            peak_cx[stored_peaks] = px;
            peak_cy[stored_peaks] = py;
            peak_amp[stored_peaks] = in_peak_height;
            peak_sigma[stored_peaks] = in_peak_spread;
            stored_peaks++;
          end
        end else begin
          r.field = field_at(px, py);
          r.region = px >= edge_left && px <= edge_right &&
                     py >= edge_bottom && py <= edge_top;
        end
        expected_results = {expected_results, r};
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_field_value !== e.field)
            report_mismatch("field_value", out_field_value, e.field);
          if (out_in_region !== e.region)
            report_mismatch("in_region", out_in_region, e.region);
          if (out_status !== e.status)
            report_mismatch("status", out_status, e.status);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

### dv/testbench.sv
// Stimulus and verdict for the Gaussian peak field evaluator.
`timescale 1ns / 100ps

module testbench;

  // No accepts on either channel for this long means the block hung.
  localparam int HANG_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 350;
  localparam int TABLE_DEPTH = gpfe_pkg::PEAKS_DEF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [15:0] in_point_x, in_point_y, in_peak_height, in_peak_spread;
  logic        out_valid;
  logic        out_ready;
  logic [23:0] out_field_value;
  logic        out_in_region, out_status;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          pending, fail_count;

  int          send_idle_pct, recv_stall_pct;
  int          quiet_cycles;
  // Centers and widths we have stored, so evaluations can aim near peaks.
  logic [15:0] aimed_cx [$];
  logic [15:0] aimed_cy [$];
  logic [15:0] aimed_sigma [$];

  gaussian_peak_field_evaluator_top dut (.*);

  gpfe_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: stalls at the phase's rate.
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Hang detector.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request; valid stays high across back-to-back requests.
  task automatic send_request(gpfe_pkg::action_t act, logic [15:0] x, logic [15:0] y,
                              logic [15:0] height, logic [15:0] sigma);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_point_x <= x;
    in_point_y <= y;
    in_peak_height <= height;
    in_peak_spread <= sigma;
    do @(posedge clk); while (!in_ready);
    if (act == gpfe_pkg::ACT_APPEND && aimed_cx.size() < TABLE_DEPTH) begin
      aimed_cx = {aimed_cx, x};
      aimed_cy = {aimed_cy, y};
      aimed_sigma = {aimed_sigma, sigma};
    end
  endtask

  // Region writes happen only with nothing in flight; every request
  // yields a result, so an empty expectation queue means idle.
  task automatic set_region(logic [15:0] l, logic [15:0] r, logic [15:0] b,
                            logic [15:0] t);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= gpfe_pkg::REG_LEFT;   cfg_data <= l; @(posedge clk);
    cfg_index <= gpfe_pkg::REG_RIGHT;  cfg_data <= r; @(posedge clk);
    cfg_index <= gpfe_pkg::REG_BOTTOM; cfg_data <= b; @(posedge clk);
    cfg_index <= gpfe_pkg::REG_TOP;    cfg_data <= t; @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int k, span;
    logic [15:0] x, y, h, s;
    x = 16'($urandom);
    y = 16'($urandom);
    h = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom);
    case ($urandom_range(3))
      0: s = 16'($urandom_range(1, 255));
      1: s = 16'($urandom_range(256, 4095));
      2: s = 16'($urandom);
      default: s = ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
    endcase
    if ((aimed_cx.size() < TABLE_DEPTH && $urandom_range(99) < 30) ||
        $urandom_range(99) < 6) begin
      send_request(gpfe_pkg::ACT_APPEND, x, y, h, s);
    end else begin
      // Mostly aim near a stored peak so the exp terms are nonzero.
      if (aimed_cx.size() > 0 && $urandom_range(99) < 75) begin
        k = $urandom_range(aimed_cx.size() - 1);
        span = 3 * int'(aimed_sigma[k]) + 1;
        if (span > 30000) span = 30000;
        x = aimed_cx[k] + 16'($urandom_range(0, 2 * span) - span);
        y = aimed_cy[k] + 16'($urandom_range(0, 2 * span) - span);
      end
      send_request(gpfe_pkg::ACT_EVAL, x, y, h, s);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = gpfe_pkg::ACT_APPEND;
    in_point_x = '0;
    in_point_y = '0;
    in_peak_height = '0;
    in_peak_spread = '0;
    cfg_we = 1'b0;
    cfg_index = gpfe_pkg::REG_LEFT;
    cfg_data = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, coordinate extremes, zero and max spread, far points.
    send_request(gpfe_pkg::ACT_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(gpfe_pkg::ACT_EVAL, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    send_request(gpfe_pkg::ACT_APPEND, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_request(gpfe_pkg::ACT_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_request(gpfe_pkg::ACT_EVAL, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send_request(gpfe_pkg::ACT_APPEND, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF);
    send_request(gpfe_pkg::ACT_APPEND, 16'h7FFF, 16'h8000, 16'h8000, 16'h0100);
    send_request(gpfe_pkg::ACT_APPEND, 16'h0100, 16'hFF00, 16'hFFFF, 16'hFFFF);
    send_request(gpfe_pkg::ACT_EVAL, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
    send_request(gpfe_pkg::ACT_EVAL, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
    send_request(gpfe_pkg::ACT_EVAL, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
    send_request(gpfe_pkg::ACT_EVAL, 16'h0200, 16'hFE00, 16'h0000, 16'h0000);

    // Small rectangle: edges are inclusive.
    set_region(16'hFF00, 16'h0100, 16'hFE00, 16'h0200);
    send_request(gpfe_pkg::ACT_EVAL, 16'hFF00, 16'h0200, 16'h0000, 16'h0000);
    send_request(gpfe_pkg::ACT_EVAL, 16'h0100, 16'hFE00, 16'h0000, 16'h0000);
    send_request(gpfe_pkg::ACT_EVAL, 16'hFEFF, 16'h0000, 16'h0000, 16'h0000);
    send_request(gpfe_pkg::ACT_EVAL, 16'h0000, 16'h0201, 16'h0000, 16'h0000);

    // Crossed edges: nothing is inside.
    set_region(16'h0064, 16'hFF9C, 16'h8000, 16'h7FFF);
    send_request(gpfe_pkg::ACT_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    set_region(16'h8000, 16'h7FFF, 16'h0064, 16'hFF9C);
    send_request(gpfe_pkg::ACT_EVAL, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

    // Fill the table, then one refused append.
    while (aimed_cx.size() < TABLE_DEPTH)
      send_request(gpfe_pkg::ACT_APPEND, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(1, 2047)));
    send_request(gpfe_pkg::ACT_APPEND, 16'h1234, 16'h4321, 16'hFFFF, 16'h0100);
    send_request(gpfe_pkg::ACT_EVAL, aimed_cx[TABLE_DEPTH-1], aimed_cy[TABLE_DEPTH-1],
                 16'h0000, 16'h0000);

    // Random phases: flow control pattern and region change per phase.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_region(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        end
        1: begin
          send_idle_pct = 88; recv_stall_pct = 0;
          set_region(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 88;
          set_region(16'hC000, 16'h4000, 16'hC000, 16'h4000);
        end
        default: begin
          send_idle_pct = 30; recv_stall_pct = 30;
          set_region(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        end
      endcase
      repeat (RANDOM_PER_PHASE) random_request();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/gpfe_pkg.sv
hdl/gpfe_ram.sv
hdl/gpfe_div.sv
hdl/gaussian_peak_field_evaluator_top.sv
dv/gpfe_checker.sv
dv/testbench.sv
